// ===== hdl/blc_pkg.sv =====
// Shared types and codes for the bounded LIFO stack.
`default_nettype none
package blc_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 6;
	localparam int OCC_W  = 7;
	localparam int REQ_W  = 2;
	localparam int STAT_W = 2;

	// Stream widths: fields packed from bit 0, padded to whole bytes.
	localparam int S_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((DATA_W + OCC_W + 7) / 8) * 8;

	typedef logic signed [DATA_W-1:0] word_t;

	// Request kinds.
	localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
	localparam logic [REQ_W-1:0] REQ_EDIT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POP  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_SHOW = 2'd3;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

	// Command broadcast to every cell of the chain; at most one bit is set.
	typedef struct packed {
		logic push;   // shift toward the bottom, new word enters at the top cell
		logic pop;    // shift toward the top
		logic rot;    // shift toward the top, top word wraps to the tail cell
		logic edit;   // overwrite the addressed cell
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/blc_cell.sv =====
// One storage cell of the stack chain.
`default_nettype none
module blc_cell #(
	parameter int IDX   = 0,
	parameter int IDX_W = 6
) (
	input  wire                  clk,
	input  blc_pkg::cell_ctrl_t  ctrl,
	input  wire [IDX_W-1:0]      tail_idx,
	input  wire [IDX_W-1:0]      edit_idx,
	input  blc_pkg::word_t       value,
	input  blc_pkg::word_t       from_above,
	input  blc_pkg::word_t       from_below,
	input  blc_pkg::word_t       wrap,
	output blc_pkg::word_t       word
);

	blc_pkg::word_t word_q;
	logic           is_tail;
	logic           is_hit;

	assign is_tail = (tail_idx == IDX_W'(IDX));
	assign is_hit  = (edit_idx == IDX_W'(IDX));

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			word_q <= from_above;
		end else if (ctrl.pop) begin
			word_q <= from_below;
		end else if (ctrl.rot) begin
			word_q <= is_tail ? wrap : from_below;
		end else if (ctrl.edit && is_hit) begin
			word_q <= value;
		end
	end

	assign word = word_q;

endmodule
`default_nettype wire

// ===== hdl/bounded_lifo_stack.sv =====
// Top level of the bounded LIFO stack: request decode, display sequencer, cell chain.
`default_nettype none
// Bounded LIFO stack of DEPTH signed 32-bit words held in a chain of cells, the
// top of stack always in cell 0. Push, edit and pop requests can follow one
// another in consecutive cycles as long as results are taken; a push shifts
// the chain down, a pop shifts it up and returns cell 0. Edit position counts
// from the bottom (0 is the oldest) and maps onto cell count-1-position. A
// display on a non-empty stack is the request transfer, then one result per
// entry, top first, while the chain rotates one step per result so that
// cell 0 always presents the next entry and the stack is back in order
// after the last one; input is held off meanwhile. A display advances only
// as its results are taken. Every result carries its status and the
// occupancy after the request, and only the final result of a request has
// tlast set. Output stalls hold the chain.
module bounded_lifo_stack #(
	parameter int DEPTH = 64
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire [blc_pkg::S_TDATA_W-1:0]       s_tdata,   // value[31:0], position[37:32], pad
	input  wire [blc_pkg::REQ_W-1:0]           s_tuser,   // req_type[1:0]
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [blc_pkg::M_TDATA_W-1:0]      m_tdata,   // data[31:0], occupancy[38:32], pad
	output logic [blc_pkg::STAT_W-1:0]         m_tuser,   // status[1:0]
	output logic                               m_tlast
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W = blc_pkg::OCC_W;
	localparam int DW    = blc_pkg::DATA_W;
	localparam int PW    = blc_pkg::POS_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SHOW = 2'b10
	} state_t;

	state_t                     state_q;
	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           remain_q;

	// Output register.
	logic                       m_valid_q;
	blc_pkg::word_t             m_data_q;
	logic [OCC_W-1:0]           m_occ_q;
	logic [blc_pkg::STAT_W-1:0] m_stat_q;
	logic                       m_last_q;

	// Decoded input fields.
	logic [blc_pkg::REQ_W-1:0]  req_type;
	blc_pkg::word_t             value;
	logic [PW-1:0]              position;

	logic                       out_free;
	logic                       accept;
	logic                       show_step;
	logic                       full;
	logic                       empty;
	logic                       pos_ok;

	logic [OCC_W-1:0]           tail_wide;
	logic [OCC_W-1:0]           edit_wide;
	logic [IDX_W-1:0]           tail_idx;
	logic [IDX_W-1:0]           edit_idx;

	blc_pkg::cell_ctrl_t        ctrl;
	blc_pkg::word_t             cells [DEPTH];

	// Next-state values computed by the decoder.
	logic [CNT_W-1:0]           count_d;
	state_t                     state_d;
	logic [CNT_W-1:0]           remain_d;
	logic                       load_out;
	blc_pkg::word_t             out_data_d;
	logic [blc_pkg::STAT_W-1:0] out_stat_d;
	logic                       out_last_d;

	assign req_type = s_tuser;
	assign value    = s_tdata[DW-1:0];
	assign position = s_tdata[DW+PW-1:DW];

	assign out_free  = !m_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && out_free;
	assign accept    = s_tvalid && s_tready;
	assign show_step = (state_q == ST_SHOW) && out_free;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign pos_ok = (OCC_W'(position) < OCC_W'(count_q));

	// Tail cell and edit target, counted from the top of the chain.
	assign tail_wide = OCC_W'(count_q) - OCC_W'(1);
	assign edit_wide = tail_wide - OCC_W'(position);
	assign tail_idx  = tail_wide[IDX_W-1:0];
	assign edit_idx  = edit_wide[IDX_W-1:0];

	// Decode the request, or advance the display.
	always_comb begin
		ctrl       = '0;
		count_d    = count_q;
		state_d    = state_q;
		remain_d   = remain_q;
		load_out   = 1'b0;
		out_data_d = '0;
		out_stat_d = blc_pkg::STAT_OK;
		out_last_d = 1'b1;
		if (accept) begin
			case (req_type)
				blc_pkg::REQ_PUSH: begin
					load_out = 1'b1;
					if (full) begin
						out_stat_d = blc_pkg::STAT_FULL;
					end else begin
						ctrl.push = 1'b1;
						count_d   = count_q + CNT_W'(1);
					end
				end
				blc_pkg::REQ_EDIT: begin
					load_out = 1'b1;
					if (pos_ok) begin
						ctrl.edit = 1'b1;
					end else begin
						out_stat_d = blc_pkg::STAT_BADPOS;
					end
				end
				blc_pkg::REQ_POP: begin
					load_out = 1'b1;
					if (empty) begin
						out_stat_d = blc_pkg::STAT_EMPTY;
					end else begin
						ctrl.pop   = 1'b1;
						out_data_d = cells[0];
						count_d    = count_q - CNT_W'(1);
					end
				end
				blc_pkg::REQ_SHOW: begin
					if (empty) begin
						load_out   = 1'b1;
						out_stat_d = blc_pkg::STAT_EMPTY;
					end else begin
						state_d  = ST_SHOW;
						remain_d = count_q;
					end
				end
				default: begin
					load_out = 1'b0;
				end
			endcase
		end else if (show_step) begin
			// Emit the top cell and rotate it to the tail.
			ctrl.rot   = 1'b1;
			load_out   = 1'b1;
			out_data_d = cells[0];
			out_last_d = (remain_q == CNT_W'(1));
			remain_d   = remain_q - CNT_W'(1);
			if (remain_q == CNT_W'(1)) begin
				state_d = ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			remain_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			remain_q <= remain_d;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result payload until the next transfer is loaded.
	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= out_data_d;
			m_occ_q  <= OCC_W'(count_d);
			m_stat_q <= out_stat_d;
			m_last_q <= out_last_d;
		end
	end

	// Cell chain, cell 0 is the top of stack.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		blc_pkg::word_t above;
		blc_pkg::word_t below;
		if (i == 0) begin : g_top
			assign above = value;
		end else begin : g_mid_top
			assign above = cells[i-1];
		end
		if (i == DEPTH - 1) begin : g_bot
			assign below = cells[i];
		end else begin : g_mid_bot
			assign below = cells[i+1];
		end
		blc_cell #(
			.IDX   (i),
			.IDX_W (IDX_W)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.tail_idx   (tail_idx),
			.edit_idx   (edit_idx),
			.value      (value),
			.from_above (above),
			.from_below (below),
			.wrap       (cells[0]),
			.word       (cells[i])
		);
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(blc_pkg::M_TDATA_W - DW - OCC_W){1'b0}}, m_occ_q, m_data_q};
	assign m_tuser  = m_stat_q;
	assign m_tlast  = m_last_q;

	// Occupancy never exceeds the chain length.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("stack occupancy above depth");

	// Never more than one chain command in a cycle.
	a_ctrl_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(ctrl))
		else $error("conflicting chain commands");

	// A display walk leaves the occupancy untouched.
	a_show_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHOW) |=> (count_q == $past(count_q)))
		else $error("occupancy changed during display");

	// A successful pop shrinks the stack by one.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == blc_pkg::REQ_POP) && !empty)
		|=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("pop did not shrink the stack");

	// The display walk never outlasts the entries held.
	a_remain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHOW) |-> (remain_q != '0) && (remain_q <= count_q))
		else $error("display walk out of range");

endmodule
`default_nettype wire
